// ----- hw/rtl/asc_pkg.sv -----
// ============================================================================
// asc_pkg: shared types and constants for the accelerometer step counter
// Widths, window length, queue depth, register map and the sequencer states.
// ============================================================================
`default_nettype none

package asc_pkg;

    localparam int AXES      = 3;
    localparam int AXIS_W    = $clog2(AXES);
    localparam int SAMPLE_W  = 14;
    localparam int SUM_W     = 17;
    localparam int THR_W     = 14;
    localparam int STEP_W    = 16;
    localparam int PCT_W     = 7;

    // samples per window, 1..7
    localparam int WINDOW    = 5;
    localparam int FILL_W    = $clog2(WINDOW + 1);

    // window average: (sum * AVG_RECIP) >> AVG_SHIFT equals sum / WINDOW,
    // truncated, for every SUM_W-bit sum and every window length 1..7
    localparam int AVG_SHIFT  = 20;
    localparam int RECIP_W    = AVG_SHIFT + 1;
    localparam logic [RECIP_W-1:0] AVG_RECIP =
        RECIP_W'(((1 << AVG_SHIFT) + WINDOW - 1) / WINDOW);
    localparam int AVG_PROD_W = SUM_W + RECIP_W;

    // divider: dividend wide enough for step_count * 100
    localparam int PROD_W    = STEP_W + PCT_W;
    localparam int DIV_CNT_W = $clog2(PROD_W);

    localparam logic [PCT_W-1:0]  PCT_FULL  = 7'd100;
    localparam logic [STEP_W-1:0] COUNT_MAX = '1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // register file
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_IDX_THRESH = 1'b0;
    localparam logic REG_IDX_GOAL   = 1'b1;
    localparam logic [THR_W-1:0]  THRESH_RESET = 14'd100;
    localparam logic [STEP_W-1:0] GOAL_RESET   = 16'd1;

    typedef struct packed {
        logic [AXES-1:0][SUM_W-1:0] sum;
    } win_t;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [STEP_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [PROD_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG,
        ST_STEP,
        ST_PCT_GO,
        ST_PCT,
        ST_OUT
    } back_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/asc_front.sv -----
// ============================================================================
// asc_front: sample intake
// Accumulates per-axis absolute differences and pushes the window sums into
// the queue when a window completes.
// ============================================================================
`default_nettype none

module asc_front
    import asc_pkg::*;
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [AXES-1:0][SAMPLE_W-1:0]   sample,
    input  wire logic                            q_full,
    output logic                                 q_push,
    output win_t                                 q_data
);

    logic [SAMPLE_W-1:0] last_reg [AXES];
    logic [SUM_W-1:0]    sum_reg  [AXES];
    logic [FILL_W-1:0]   fill_reg;

    logic [SUM_W-1:0]    sum_next [AXES];
    logic [FILL_W-1:0]   fill_next;
    logic                accept;
    logic                win_done;

    assign in_stall  = q_full;
    assign accept    = in_valid && !in_stall;
    assign fill_next = fill_reg + FILL_W'(1);
    assign win_done  = (fill_next == FILL_W'(WINDOW));

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            logic [SAMPLE_W-1:0] d;
            d = (sample[a] >= last_reg[a]) ? (sample[a] - last_reg[a])
                                           : (last_reg[a] - sample[a]);
            sum_next[a] = sum_reg[a] + SUM_W'(d);
            q_data.sum[a] = sum_next[a];
        end
    end

    assign q_push = accept && win_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            for (int a = 0; a < AXES; a++)
            begin
                last_reg[a] <= '0;
                sum_reg[a]  <= '0;
            end
        end
        else if (accept)
        begin
            fill_reg <= win_done ? '0 : fill_next;
            for (int a = 0; a < AXES; a++)
            begin
                last_reg[a] <= sample[a];
                sum_reg[a]  <= win_done ? '0 : sum_next[a];
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/asc_fifo.sv -----
// ============================================================================
// asc_fifo: window queue
// Short register queue of completed window sums between intake and back end.
// ============================================================================
`default_nettype none

module asc_fifo
    import asc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  win_t       push_data,
    output logic       full,
    input  wire logic  pop,
    output win_t       head,
    output logic       empty
);

    win_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;

    logic do_push;
    logic do_pop;

    assign full    = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + QCNT_W'(1);
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("window queue overflow");

endmodule

`default_nettype wire

// ----- hw/rtl/asc_div.sv -----
// ============================================================================
// asc_div: iterative divider
// Restoring shift-subtract divider, one quotient bit per cycle, for the
// percent-of-goal result.
// ============================================================================
`default_nettype none

module asc_div
    import asc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  div_req_t  req,
    output div_rsp_t  rsp
);

    logic [STEP_W-1:0]    rem_reg;
    logic [PROD_W-1:0]    quo_reg;
    logic [STEP_W-1:0]    dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [STEP_W:0] shifted;
    logic [STEP_W:0] diff;
    logic            ge;

    assign shifted = {rem_reg, quo_reg[PROD_W-1]};
    assign ge      = (shifted >= {1'b0, dvs_reg});
    assign diff    = shifted - {1'b0, dvs_reg};

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(PROD_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so it fits STEP_W bits
            rem_reg <= ge ? diff[STEP_W-1:0] : shifted[STEP_W-1:0];
            quo_reg <= {quo_reg[PROD_W-2:0], ge};
        end
    end

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.start && busy_reg))
        else $error("divider started while busy");

endmodule

`default_nettype wire

// ----- hw/rtl/asc_back.sv -----
// ============================================================================
// asc_back: window evaluation
// Pops window sums, forms the averages and step decision, runs the percent
// division and holds the result register for the output channel.
// ============================================================================
`default_nettype none

module asc_back
    import asc_pkg::*;
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [THR_W-1:0]               step_threshold,
    input  wire logic [STEP_W-1:0]              goal_limit,
    input  win_t                                q_head,
    input  wire logic                           q_empty,
    output logic                                q_pop,
    output div_req_t                            div_req,
    input  div_rsp_t                            div_rsp,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [AXES-1:0][SAMPLE_W-1:0]       avg,
    output logic [STEP_W-1:0]                   step_total,
    output logic                                step_seen,
    output logic [PCT_W-1:0]                    percent_of_goal
);

    localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(AXES - 1);

    back_state_t          state_reg, state_next;
    logic [AXIS_W-1:0]    axis_reg;
    logic [AXIS_W-1:0]    axis_nxt;
    logic [STEP_W-1:0]    step_count_reg;
    logic [SAMPLE_W-1:0]  prev_reg [AXES];
    logic                 out_valid_reg;

    win_t                 win_reg;
    logic [SAMPLE_W-1:0]  avg_reg [AXES];
    logic                 seen_reg;
    logic [PCT_W-1:0]     pct_reg;

    logic [AXES-1:0][SAMPLE_W-1:0] out_avg_reg;
    logic [STEP_W-1:0]    out_total_reg;
    logic                 out_seen_reg;
    logic [PCT_W-1:0]     out_pct_reg;

    logic                 out_free;
    logic                 pct_sat;
    logic                 seen;
    logic                 load_out;
    logic [AVG_PROD_W-1:0] avg_prod;

    assign axis_nxt = axis_reg + AXIS_W'(1);
    assign out_free = !out_valid_reg || !out_stall;
    // count >= goal (also goal of zero) means 100 percent, no division
    assign pct_sat  = (step_count_reg >= goal_limit);

    // one axis average per cycle by reciprocal multiply
    assign avg_prod = AVG_PROD_W'(win_reg.sum[axis_reg]) * AVG_PROD_W'(AVG_RECIP);

    // threshold sum formed one bit wider so it never wraps
    always_comb
    begin
        seen = 1'b0;
        for (int a = 0; a < AXES; a++)
        begin
            if ({1'b0, avg_reg[a]} > ({1'b0, prev_reg[a]} + {1'b0, step_threshold}))
                seen = 1'b1;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (!q_empty)
                    state_next = ST_AVG;
            ST_AVG:
                if (axis_reg == LAST_AXIS)
                    state_next = ST_STEP;
            ST_STEP:
                state_next = ST_PCT_GO;
            ST_PCT_GO:
                state_next = pct_sat ? ST_OUT : ST_PCT;
            ST_PCT:
                if (div_rsp.done)
                    state_next = ST_OUT;
            ST_OUT:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        q_pop            = 1'b0;
        load_out         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        unique case (state_reg)
            ST_IDLE:
                q_pop = !q_empty;
            ST_AVG:
                ;
            ST_STEP:
                ;
            ST_PCT_GO:
                if (!pct_sat)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = PROD_W'(step_count_reg) * PROD_W'(PCT_FULL);
                    div_req.divisor  = goal_limit;
                end
            ST_PCT:
                ;
            ST_OUT:
                load_out = out_free;
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            axis_reg       <= '0;
            step_count_reg <= '0;
            out_valid_reg  <= 1'b0;
            for (int a = 0; a < AXES; a++)
                prev_reg[a] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE)
                axis_reg <= '0;
            else if (state_reg == ST_AVG)
                axis_reg <= axis_nxt;
            if (state_reg == ST_STEP && seen && step_count_reg != COUNT_MAX)
                step_count_reg <= step_count_reg + STEP_W'(1);
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                for (int a = 0; a < AXES; a++)
                    prev_reg[a] <= avg_reg[a];
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            win_reg <= q_head;
        if (state_reg == ST_AVG)
            avg_reg[axis_reg] <= avg_prod[AVG_SHIFT +: SAMPLE_W];
        if (state_reg == ST_STEP)
            seen_reg <= seen;
        if (state_reg == ST_PCT_GO && pct_sat)
            pct_reg <= PCT_FULL;
        else if (state_reg == ST_PCT && div_rsp.done)
            pct_reg <= div_rsp.quotient[PCT_W-1:0];
        if (load_out)
        begin
            for (int a = 0; a < AXES; a++)
                out_avg_reg[a] <= avg_reg[a];
            out_total_reg <= step_count_reg;
            out_seen_reg  <= seen_reg;
            out_pct_reg   <= pct_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign avg             = out_avg_reg;
    assign step_total      = out_total_reg;
    assign step_seen       = out_seen_reg;
    assign percent_of_goal = out_pct_reg;

    a_pct_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_pct_reg <= PCT_FULL))
        else $error("percent above full scale");

    a_seen_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_seen_reg) |-> (out_total_reg != '0))
        else $error("step flagged with zero total");

    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        step_count_reg >= $past(step_count_reg))
        else $error("step count went backwards");

endmodule

`default_nettype wire

// ----- hw/rtl/accel_activity_step_counter.sv -----
// ============================================================================
// accel_activity_step_counter: three-axis accelerometer step counter
// Windowed activity averages, step detection and percent of goal.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_stall, sample_x/y/z): one sample per transfer.
//   The intake takes a sample every cycle while the window queue has room;
//   in_stall rises only when the queue is full.
//   Every WINDOW-th sample closes a window and yields one output transfer
//   (out_valid/out_stall) with the three averages, step total, step flag and
//   percent of goal; other samples yield nothing.
//   Per window the back end forms the three averages by reciprocal multiply,
//   one axis per cycle, then runs a one-bit-per-cycle divider for the
//   percent unless the percent saturates, in which case no division runs.
//   The back end takes no new window until the last one's result is loaded
//   into the result register; the percent divider is the rate-setting unit.
//   While out_stall is high the result register holds; the back end finishes
//   the next window and waits, and the queue keeps taking samples until full.
//   Reset clears sums, last samples, previous averages and the step count;
//   step_threshold resets to 100 and step_goal to 1. The user must write the registers
//   over the APB port only while the block is idle; the block does not enforce it.
// ============================================================================
`default_nettype none

module accel_activity_step_counter
    import asc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [PADDR_W-1:0]   paddr,
    input  wire logic [PDATA_W-1:0]   pwdata,
    output logic      [PDATA_W-1:0]   prdata,
    output logic                      pready,

    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [SAMPLE_W-1:0]  sample_x,
    input  wire logic [SAMPLE_W-1:0]  sample_y,
    input  wire logic [SAMPLE_W-1:0]  sample_z,

    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [SAMPLE_W-1:0]       avg_x,
    output logic [SAMPLE_W-1:0]       avg_y,
    output logic [SAMPLE_W-1:0]       avg_z,
    output logic [STEP_W-1:0]         step_total,
    output logic                      step_seen,
    output logic [PCT_W-1:0]          percent_of_goal
);

    logic [THR_W-1:0]  thresh_reg;
    logic [STEP_W-1:0] goal_reg;
    logic              reg_wr;

    logic [AXES-1:0][SAMPLE_W-1:0] sample;
    logic [AXES-1:0][SAMPLE_W-1:0] avg;

    logic     q_push;
    win_t     q_push_data;
    logic     q_full;
    logic     q_pop;
    win_t     q_head;
    logic     q_empty;
    div_req_t div_req;
    div_rsp_t div_rsp;

    // register file: index taken from paddr[2]
    assign pready = 1'b1;
    assign reg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
            goal_reg   <= GOAL_RESET;
        end
        else if (reg_wr)
        begin
            if (paddr[2] == REG_IDX_GOAL)
                goal_reg <= pwdata[STEP_W-1:0];
            else
                thresh_reg <= pwdata[THR_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_IDX_GOAL) ? PDATA_W'(goal_reg)
                                               : PDATA_W'(thresh_reg);

    assign sample = {sample_z, sample_y, sample_x};
    assign avg_x  = avg[0];
    assign avg_y  = avg[1];
    assign avg_z  = avg[2];

    asc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sample   (sample),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_push_data)
    );

    asc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    asc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    asc_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .step_threshold  (thresh_reg),
        .goal_limit      (goal_reg),
        .q_head          (q_head),
        .q_empty         (q_empty),
        .q_pop           (q_pop),
        .div_req         (div_req),
        .div_rsp         (div_rsp),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .avg             (avg),
        .step_total      (step_total),
        .step_seen       (step_seen),
        .percent_of_goal (percent_of_goal)
    );

endmodule

`default_nettype wire

// ----- dv/accel_activity_step_counter_test.sv -----
// ----------------------------------------------------------------------------
// accel_activity_step_counter_test: window average and step detection check
// Feeds three-axis samples over the valid/stall input with random gaps,
// stalls the result side at random, and holds its own model of the window
// sums, averages, step count and percent of goal. Every result transfer is
// checked against the oldest predicted window. Threshold and goal are
// rewritten over APB between phases while the block is idle.
// ----------------------------------------------------------------------------
module accel_activity_step_counter_test
    import asc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [PADDR_W-1:0] ADDR_THRESH = {REG_IDX_THRESH, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_GOAL   = {REG_IDX_GOAL, 2'b00};
    localparam int unsigned SAMPLE_MAX  = (1 << SAMPLE_W) - 1;
    localparam int unsigned SETTLE      = 200;
    localparam int unsigned QUIET_LIMIT = 5000;
    localparam int unsigned PHASES      = 6;
    localparam int unsigned PHASE_ITEMS = 236;

    typedef struct packed {
        logic [SAMPLE_W-1:0] x;
        logic [SAMPLE_W-1:0] y;
        logic [SAMPLE_W-1:0] z;
    } accel_sample_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] ax;
        logic [SAMPLE_W-1:0] ay;
        logic [SAMPLE_W-1:0] az;
        logic [STEP_W-1:0]   steps;
        logic                seen;
        logic [PCT_W-1:0]    pct;
    } window_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [SAMPLE_W-1:0] sample_x = '0;
    logic [SAMPLE_W-1:0] sample_y = '0;
    logic [SAMPLE_W-1:0] sample_z = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [SAMPLE_W-1:0] avg_x;
    logic [SAMPLE_W-1:0] avg_y;
    logic [SAMPLE_W-1:0] avg_z;
    logic [STEP_W-1:0]   step_total;
    logic                step_seen;
    logic [PCT_W-1:0]    percent_of_goal;

    accel_activity_step_counter uut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // model state
    logic [THR_W-1:0]    thr_cfg = THRESH_RESET;
    logic [STEP_W-1:0]   goal_cfg = GOAL_RESET;
    logic [SAMPLE_W-1:0] prior [AXES] = '{default: '0};
    logic [SUM_W-1:0]    motion_sum [AXES] = '{default: '0};
    logic [SAMPLE_W-1:0] last_avg [AXES] = '{default: '0};
    logic [FILL_W-1:0]   fill = '0;
    logic [STEP_W-1:0]   step_count = '0;

    accel_sample_t  pending_samples[$];
    window_result_t expected_windows[$];

    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    logic        in_took = 1'b0;

    function automatic int unsigned draw_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // accumulate one sample; on window close push the predicted result
    task automatic track_sample(input logic [SAMPLE_W-1:0] sx, sy, sz);
        logic [SAMPLE_W-1:0] s [AXES];
        logic [SAMPLE_W-1:0] avg [AXES];
        logic [SUM_W-1:0]    delta;
        logic                seen;
        int unsigned         pct;
        window_result_t      r;
        s[0] = sx;
        s[1] = sy;
        s[2] = sz;
        for (int a = 0; a < AXES; a++)
        begin
            delta = (s[a] >= prior[a]) ? s[a] - prior[a] : prior[a] - s[a];
            motion_sum[a] = motion_sum[a] + delta;
            prior[a] = s[a];
        end
        fill = fill + 1'b1;
        if (fill < WINDOW)
            return;
        seen = 1'b0;
        for (int a = 0; a < AXES; a++)
        begin
            avg[a] = SAMPLE_W'(motion_sum[a] / WINDOW);
            // sum formed at 32 bits so a large threshold cannot wrap
            if (32'(avg[a]) > 32'(last_avg[a]) + 32'(thr_cfg))
                seen = 1'b1;
        end
        if (seen && step_count != COUNT_MAX)
            step_count = step_count + 1'b1;
        if (goal_cfg == 0)
            pct = PCT_FULL;
        else
            pct = (32'(step_count) * PCT_FULL) / 32'(goal_cfg);
        if (pct > PCT_FULL)
            pct = PCT_FULL;
        r.ax = avg[0];
        r.ay = avg[1];
        r.az = avg[2];
        r.steps = step_count;
        r.seen = seen;
        r.pct = PCT_W'(pct);
        expected_windows.push_back(r);
        for (int a = 0; a < AXES; a++)
        begin
            last_avg[a] = avg[a];
            motion_sum[a] = '0;
        end
        fill = '0;
    endtask

    // input side: one transfer per item, random gaps, calm stretches
    int unsigned in_gap = 0;
    int unsigned in_calm = 0;

    always @(negedge clk)
    begin : driver
        accel_sample_t smp;
        int unsigned   gap;
        if (rst_n)
        begin
            if (in_valid && !in_took)
            begin
                // held until the transfer happens
            end
            else if (in_gap > 0)
            begin
                in_valid <= 1'b0;
                in_gap <= in_gap - 1;
            end
            else if (pending_samples.size() > 0)
            begin
                smp = pending_samples.pop_front();
                in_valid <= 1'b1;
                sample_x <= smp.x;
                sample_y <= smp.y;
                sample_z <= smp.z;
                if (in_calm > 0)
                begin
                    in_calm = in_calm - 1;
                    gap = 0;
                end
                else
                begin
                    if ($urandom_range(0, 49) == 0)
                        in_calm = $urandom_range(20, 80);
                    gap = draw_gap();
                end
                in_gap <= gap;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result side stall pattern
    int unsigned stall_left = 0;
    int unsigned out_calm = 0;

    always @(negedge clk)
    begin : sink
        int unsigned n;
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (out_calm > 0)
        begin
            out_stall <= 1'b0;
            out_calm = out_calm - 1;
        end
        else
        begin
            n = draw_gap();
            if (n > 0)
            begin
                out_stall <= 1'b1;
                stall_left <= n - 1;
            end
            else
                out_stall <= 1'b0;
            if ($urandom_range(0, 49) == 0)
                out_calm = $urandom_range(20, 200);
        end
    end

    always @(posedge clk)
    begin : monitor
        window_result_t got;
        window_result_t want;
        in_took <= in_valid && !in_stall;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                track_sample(sample_x, sample_y, sample_z);
            if (out_valid && !out_stall)
            begin
                got = '{avg_x, avg_y, avg_z, step_total, step_seen, percent_of_goal};
                if (expected_windows.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result transfer with nothing expected: ",
                                 $realtime,
                                 "x=%0d y=%0d z=%0d steps=%0d seen=%0b pct=%0d",
                                 got.ax, got.ay, got.az, got.steps, got.seen, got.pct);
                end
                else
                begin
                    want = expected_windows.pop_front();
                    if (got.ax !== want.ax || got.ay !== want.ay || got.az !== want.az ||
                        got.steps !== want.steps || got.seen !== want.seen ||
                        got.pct !== want.pct)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: mismatch want ", $realtime,
                                     "x=%0d y=%0d z=%0d steps=%0d seen=%0b pct=%0d",
                                     want.ax, want.ay, want.az, want.steps,
                                     want.seen, want.pct);
                            $display("%0t:           got ", $realtime,
                                     "x=%0d y=%0d z=%0d steps=%0d seen=%0b pct=%0d",
                                     got.ax, got.ay, got.az, got.steps,
                                     got.seen, got.pct);
                        end
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", quiet_cycles);
                $display("FAIL accel_activity_step_counter");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_THRESH)
            thr_cfg = data[THR_W-1:0];
        else
            goal_cfg = data[STEP_W-1:0];
        @(posedge clk);
    endtask

    // all items sent and all windows back, then let the back end drain
    task automatic wait_idle();
        while (pending_samples.size() > 0 || in_valid || expected_windows.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // toggle: alternate lo/hi (y in opposite phase); else uniform in [lo, hi]
    task automatic queue_samples(input int n, input int unsigned lo, input int unsigned hi,
                                 input bit toggle);
        accel_sample_t smp;
        for (int k = 0; k < n; k++)
        begin
            if (toggle)
            begin
                smp.x = SAMPLE_W'((k % 2 == 0) ? hi : lo);
                smp.y = SAMPLE_W'((k % 2 == 0) ? lo : hi);
                smp.z = smp.x;
            end
            else
            begin
                smp.x = SAMPLE_W'($urandom_range(hi, lo));
                smp.y = SAMPLE_W'($urandom_range(hi, lo));
                smp.z = SAMPLE_W'($urandom_range(hi, lo));
            end
            pending_samples.push_back(smp);
        end
    endtask

    // whole windows of varied activity, with some noise bursts of 1 to 9 samples
    task automatic queue_random_phase(input int target);
        int unsigned mode;
        int unsigned amp;
        int unsigned base;
        int          len;
        int          n;
        bit          toggle;
        n = 0;
        while (n < target)
        begin
            mode = $urandom_range(0, 9);
            len = WINDOW;
            toggle = 1'b0;
            if (mode <= 3)
                amp = $urandom_range(0, 200);
            else if (mode <= 6)
                amp = $urandom_range(200, 4000);
            else if (mode == 7)
            begin
                amp = $urandom_range(0, SAMPLE_MAX);
                toggle = 1'b1;
            end
            else
            begin
                amp = SAMPLE_MAX;
                if (mode == 9)
                    len = $urandom_range(1, 9);
            end
            base = $urandom_range(0, SAMPLE_MAX - amp);
            queue_samples(len, base, base + amp, toggle);
            n += len;
        end
    endtask

    initial
    begin : stimulus
        int unsigned thr;
        int unsigned goal;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: first sample against zero, full swing, percent exactly full
        queue_samples(5, 0, SAMPLE_MAX, 1'b1);
        wait_idle();
        // widest threshold on a full average must not wrap; zero goal reads full
        write_reg(ADDR_THRESH, SAMPLE_MAX);
        write_reg(ADDR_GOAL, 0);
        queue_samples(5, 0, SAMPLE_MAX, 1'b1);
        wait_idle();
        // zero threshold: a tiny rise counts; goal of one pushes percent past full
        write_reg(ADDR_THRESH, 0);
        write_reg(ADDR_GOAL, 1);
        queue_samples(10, 8000, 8000, 1'b1);
        queue_samples(5, 8000, 8002, 1'b1);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    thr = $urandom_range(0, 300);
                    goal = $urandom_range(1, 20);
                end
                1:
                begin
                    thr = SAMPLE_MAX;
                    goal = (1 << STEP_W) - 1;
                end
                2:
                begin
                    thr = 0;
                    goal = $urandom_range(1, 5);
                end
                3:
                begin
                    thr = $urandom_range(0, SAMPLE_MAX);
                    goal = $urandom_range(1, (1 << STEP_W) - 1);
                end
                4:
                begin
                    thr = $urandom_range(0, 2000);
                    goal = $urandom_range(50, 400);
                end
                default:
                begin
                    thr = $urandom_range(0, SAMPLE_MAX);
                    goal = 0;
                end
            endcase
            wait_idle();
            write_reg(ADDR_THRESH, thr);
            write_reg(ADDR_GOAL, goal);
            queue_random_phase(PHASE_ITEMS);
        end

        wait_idle();
        if (mismatches == 0 && expected_windows.size() == 0)
            $display("PASS accel_activity_step_counter");
        else
            $display("FAIL accel_activity_step_counter");
        $finish;
    end

endmodule
